/* sv/ilist_pkg.sv */
// Package for the indexed list unit: command codes, field widths and the
// control struct that the top level hands to every list cell. No dependencies.
package ilist_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 5;
    localparam int COUNT_W      = 5;
    localparam int CMD_W        = 3;
    localparam int CAPACITY_DEF = 16;

    localparam logic [DATA_W-1:0] READ_MISS = {DATA_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_READ        = 3'd0,
        CMD_INSERT_HEAD = 3'd1,
        CMD_INSERT_TAIL = 3'd2,
        CMD_INSERT_POS  = 3'd3,
        CMD_DELETE_POS  = 3'd4
    } cmd_t;

    // Broadcast control for the cell row: at most one of the two is set.
    typedef struct packed {
        logic ins;
        logic del;
    } cell_ctl_t;

endpackage

/* sv/indexed_list_insert_delete_unit.sv */
// Indexed list unit: a bounded ordered list of signed 32-bit values in a row of cells.
// A request's result is registered and appears in the cycle after it is accepted.
// Throughput: one request per cycle unless stalled; insert/delete shift all cells at once.
// Reset clears the element count and the result valid flag; cell contents stay undefined.
// Depends on ilist_pkg and ilist_cell.
module indexed_list_insert_delete_unit
    import ilist_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [CMD_W-1:0]         command,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] read_value,
    output logic                     found,
    output logic                     accepted,
    output logic [COUNT_W-1:0]       count
);

    // The internal count must hold CAPACITY itself. Position comparisons are
    // done at the wider of the count width and the position field width.
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    // Only the first 32 cells can be addressed by the position field of a read.
    localparam int RD_N  = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    logic                     out_valid_reg;
    logic [DATA_W-1:0]        read_value_reg;
    logic                     found_reg;
    logic                     accepted_reg;
    logic [COUNT_W-1:0]       count_reg;

    logic              in_fire;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic [CMP_W-1:0]  ins_pos;
    logic              is_insert;
    logic              is_delete;
    logic              is_read;
    logic              full;
    logic              ins_ok;
    logic              del_ok;
    logic              rd_hit;
    logic [DATA_W-1:0] rd_mux;
    logic [DATA_W-1:0] rd_result;
    logic              acc_result;
    cell_ctl_t         ctl;

    logic [DATA_W-1:0] cell_data  [CAPACITY];
    logic [DATA_W-1:0] cell_left  [CAPACITY];
    logic [DATA_W-1:0] cell_right [CAPACITY];

    // The output register parts the two sides: a new request is taken while
    // the result slot is empty or its current result is leaving this cycle.
    assign in_stall = out_valid_reg && out_stall;
    assign in_fire  = in_valid && !in_stall;

    assign pos_ext = CMP_W'(position);
    assign cnt_ext = CMP_W'(cnt_reg);
    assign full    = (cnt_reg == CAP_CNT);

    // Decode the command. The head and tail inserts are positional inserts
    // at zero and at the current count; unused codes neither read nor change the list.
    always_comb
    begin
        is_read   = 1'b0;
        is_insert = 1'b0;
        is_delete = 1'b0;
        ins_pos   = pos_ext;
        unique case (command)
            CMD_READ:
            begin
                is_read = 1'b1;
            end
            CMD_INSERT_HEAD:
            begin
                is_insert = 1'b1;
                ins_pos   = '0;
            end
            CMD_INSERT_TAIL:
            begin
                is_insert = 1'b1;
                ins_pos   = cnt_ext;
            end
            CMD_INSERT_POS:
            begin
                is_insert = 1'b1;
            end
            CMD_DELETE_POS:
            begin
                is_delete = 1'b1;
            end
            default:
            begin
                is_read = 1'b0;
            end
        endcase
    end

    // An insert needs a free cell and a position no further than the tail.
    // A delete or a read needs a position that holds an element.
    assign ins_ok = is_insert && !full && (ins_pos <= cnt_ext);
    assign del_ok = is_delete && (pos_ext < cnt_ext);
    assign rd_hit = is_read && (pos_ext < cnt_ext);

    assign ctl.ins = in_fire && ins_ok;
    assign ctl.del = in_fire && del_ok;

    // Read selection over the addressable cells. A hit guarantees the
    // position is below the count, so a selected cell always holds data.
    always_comb
    begin
        rd_mux = '0;
        for (int i = 0; i < RD_N; i++)
        begin
            if (POS_W'(i) == position)
            begin
                rd_mux = cell_data[i];
            end
        end
    end

    always_comb
    begin
        if (rd_hit)
        begin
            rd_result = rd_mux;
        end
        else if (is_read)
        begin
            rd_result = READ_MISS;
        end
        else
        begin
            rd_result = '0;
        end
    end

    assign acc_result = rd_hit || ins_ok || del_ok;

    // The count moves by one on an accepted insert or delete.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctl.ins)
        begin
            cnt_next = cnt_reg + CNT_ONE;
        end
        else if (ctl.del)
        begin
            cnt_next = cnt_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; the reported count is the count after the request,
    // taken modulo the width of the count field.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            read_value_reg <= rd_result;
            found_reg      <= rd_hit;
            accepted_reg   <= acc_result;
            count_reg      <= COUNT_W'(cnt_next);
        end
    end

    // The cell row. On insert every cell past the insert point takes its
    // left neighbor and the cell at the point takes the new value; on delete
    // every cell from the point on takes its right neighbor.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        if (g == 0)
        begin : g_first
            assign cell_left[g] = value;
        end
        else
        begin : g_inner_left
            assign cell_left[g] = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign cell_right[g] = cell_data[g];
        end
        else
        begin : g_inner_right
            assign cell_right[g] = cell_data[g+1];
        end

        ilist_cell #(
            .IDX   (g),
            .IDX_W (CMP_W)
        ) u_cell (
            .clk   (clk),
            .ctl   (ctl),
            .pos   (ins_ok ? ins_pos : pos_ext),
            .value (value),
            .left  (cell_left[g]),
            .right (cell_right[g]),
            .data  (cell_data[g])
        );
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign found      = found_reg;
    assign accepted   = accepted_reg;
    assign count      = count_reg;

    // The list never holds more elements than it has cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CAP_CNT)
        else $error("element count exceeds capacity");

    // An accepted insert grows the list by exactly one element.
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ins |=> cnt_reg == CNT_W'($past(cnt_reg) + CNT_ONE))
        else $error("insert did not grow the count by one");

    // An accepted delete shrinks the list by exactly one element.
    a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.del |=> cnt_reg == CNT_W'($past(cnt_reg) - CNT_ONE))
        else $error("delete did not shrink the count by one");

    // Every accepted request leaves a result in the output register.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted request left no result");

    // A read hit is always reported as accepted.
    a_found_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && found_reg |-> accepted_reg)
        else $error("found result not flagged as accepted");

endmodule

/* sv/ilist_cell.sv */
// One cell of the list row: holds a single element and takes a neighbor's
// value when an insert or delete shifts the row. Depends on ilist_pkg.
module ilist_cell
    import ilist_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int IDX_W = 5
)
(
    input  logic              clk,
    input  cell_ctl_t         ctl,
    input  logic [IDX_W-1:0]  pos,
    input  logic [DATA_W-1:0] value,
    input  logic [DATA_W-1:0] left,
    input  logic [DATA_W-1:0] right,
    output logic [DATA_W-1:0] data
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // An idle cycle matches neither branch and the cell keeps its element.
    always_comb
    begin
        data_next = data_reg;
        if (ctl.ins)
        begin
            if (MY_IDX == pos)
            begin
                data_next = value;
            end
            else if (MY_IDX > pos)
            begin
                data_next = left;
            end
        end
        else if (ctl.del)
        begin
            if (MY_IDX >= pos)
            begin
                data_next = right;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
